// File: rtl/mia_pkg.sv
`timescale 1ns / 1ps

package mia_pkg;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_LOAD,
        ST_MUL,
        ST_WB,
        ST_ABS,
        ST_CMP,
        ST_DRD,
        ST_DLD,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Multiply-accumulate steps of one 3x3 minor.  The T steps build the three
    // 2x2 minors of the lower rows, the S steps expand along the top row.
    typedef enum logic [3:0] {
        OP_T0_P,
        OP_T0_N,
        OP_T1_P,
        OP_T1_N,
        OP_T2_P,
        OP_T2_N,
        OP_S0,
        OP_S1,
        OP_S2
    } op_t;

    localparam logic [3:0] LAST_ENTRY = 4'd15;
    localparam logic [1:0] LAST_DET_TERM = 2'd3;

    // Maps a row or column of the 3x3 minor back to the 4x4 matrix.
    function automatic logic [1:0] skip_map(input logic [1:0] skip, input logic [1:0] pos);
        return (pos < skip) ? pos : pos + 2'd1;
    endfunction

    // Minor position {row, col} of the serial (bitwise) operand of a step.
    function automatic logic [3:0] op_a_pos(input op_t op);
        case (op)
            OP_T0_P: return {2'd1, 2'd1};
            OP_T0_N: return {2'd1, 2'd2};
            OP_T1_P: return {2'd1, 2'd0};
            OP_T1_N: return {2'd1, 2'd2};
            OP_T2_P: return {2'd1, 2'd0};
            OP_T2_N: return {2'd1, 2'd1};
            OP_S0:   return {2'd0, 2'd0};
            OP_S1:   return {2'd0, 2'd1};
            OP_S2:   return {2'd0, 2'd2};
            default: return {2'd0, 2'd0};
        endcase
    endfunction

    // Minor position {row, col} of the parallel operand of a T step.
    function automatic logic [3:0] op_b_pos(input op_t op);
        case (op)
            OP_T0_P: return {2'd2, 2'd2};
            OP_T0_N: return {2'd2, 2'd1};
            OP_T1_P: return {2'd2, 2'd2};
            OP_T1_N: return {2'd2, 2'd0};
            OP_T2_P: return {2'd2, 2'd1};
            OP_T2_N: return {2'd2, 2'd0};
            default: return {2'd2, 2'd0};
        endcase
    endfunction

endpackage

// File: rtl/matrix_inverse_4x4.sv
`timescale 1ns / 1ps

// 4x4 matrix inverter by the adjugate method in signed fixed point. Each input
// beat writes one element (row, column, value) into a 16-entry element memory
// that reads as zero after reset; a beat with go set also starts the inversion
// once its element is stored. The sixteen cofactors are formed exactly by one
// shared bit-serial multiply-accumulate unit and kept in a cofactor memory;
// the determinant follows by expansion along the first row. Then sixteen
// output beats leave in row-major order, last set on the final one: each is
// cofactor over determinant, rounded to nearest with ties away from zero and
// saturated to the element width, or zero with singular set when the
// determinant magnitude is zero or below singular_threshold (in units of
// 2^-32). The multiply-accumulate unit forms 148 products, one multiplier bit
// per cycle, and a restoring divider then forms each output beat; input is
// not taken during that time. Outputs sit in a register, so the divider runs
// ahead while a result waits. Threshold writes are held off while an
// inversion is in progress.

module matrix_inverse_4x4 #(
    parameter int ELEM_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_elem_row,
    input  logic [1:0]                    s_elem_col,
    input  logic signed [ELEM_WIDTH-1:0]  s_elem_value,
    input  logic                          s_go,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_out_row,
    output logic [1:0]                    m_out_col,
    output logic signed [ELEM_WIDTH-1:0]  m_out_value,
    output logic                          m_singular,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [31:0]                   cfg_data
);

    import mia_pkg::*;

    localparam int EW  = ELEM_WIDTH;
    // Width of cofactors, determinant and the accumulator, with headroom.
    localparam int W   = 4 * EW + 8;
    localparam int CW  = W + 32 + 4 * FRAC_BITS;
    localparam int DW  = W + 2 * FRAC_BITS + EW + 4;
    localparam int MCW = $clog2(EW);
    localparam logic [W-1:0] ONE_W = W'(1);
    localparam logic [EW+1:0] LIM_NEG = (EW + 2)'(1) << (EW - 1);
    localparam logic [EW+1:0] LIM_POS = LIM_NEG - (EW + 2)'(1);

    state_t state_reg, state_next;

    // Element memory with per-entry valid bits for the cleared reset state.
    logic [EW-1:0] mat_mem [16];
    logic [15:0]   vld_reg;
    logic [EW-1:0] mat_rd_reg;
    logic          mat_rdv_reg;
    logic [3:0]    mat_addr;
    logic [EW-1:0] mat_data;

    // Cofactor memory.
    logic [W-1:0]  adj_mem [16];
    logic [W-1:0]  adj_rd_reg;
    logic [3:0]    adj_raddr;
    logic [W-1:0]  adj_wdata;
    logic          adj_we;

    logic [31:0]   thr_reg;

    op_t           op_reg;
    logic [3:0]    k_reg;
    logic [1:0]    dk_reg;
    logic          det_ph_reg;
    logic [3:0]    ok_reg;

    logic [EW-1:0]  mplier_reg;
    logic [W-1:0]   mcand_reg;
    logic [W-1:0]   acc_reg;
    logic [MCW-1:0] cnt_reg;
    logic [W-1:0]   t0_reg, t1_reg, t2_reg;
    logic [W-1:0]   dabs_reg;
    logic           det_neg_reg;
    logic           sing_reg;
    logic           cneg_reg;

    logic [W-1:0]   b_sel;
    logic [W-1:0]   addend;
    logic [W-1:0]   acc_sum;
    logic           op_neg;
    logic           op_clr;
    logic           mul_last;
    logic           s_fire;
    logic           out_load;
    logic           div_start;
    logic           div_done;
    logic [EW+1:0]  div_q;
    logic [W-1:0]   cabs;
    logic [DW-1:0]  div_num;
    logic [DW-1:0]  div_den;
    logic [CW-1:0]  thr_lhs, thr_rhs;
    logic [EW+1:0]  q_sat;
    logic [EW+1:0]  q_neg;
    logic [EW-1:0]  out_val;

    logic          m_valid_reg;
    logic [1:0]    m_row_reg, m_col_reg;
    logic [EW-1:0] m_val_reg;
    logic          m_sing_reg, m_last_reg;

    logic [1:0] cof_i, cof_j;
    logic [3:0] a_pos, b_pos;

    assign cof_i = k_reg[3:2];
    assign cof_j = k_reg[1:0];
    assign a_pos = op_a_pos(op_reg);
    assign b_pos = op_b_pos(op_reg);

    // The minor of adjugate entry (i, j) drops row j and column i.
    always_comb begin
        case (state_reg)
            ST_RDA:  mat_addr = det_ph_reg ? {2'b00, dk_reg}
                                           : {skip_map(cof_j, a_pos[3:2]),
                                              skip_map(cof_i, a_pos[1:0])};
            ST_RDB:  mat_addr = {skip_map(cof_j, b_pos[3:2]),
                                 skip_map(cof_i, b_pos[1:0])};
            default: mat_addr = 4'd0;
        endcase
    end

    assign adj_raddr = (state_reg == ST_RDB) ? {dk_reg, 2'b00} : ok_reg;
    assign mat_data  = mat_rdv_reg ? mat_rd_reg : '0;

    // Control decode.
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        s_fire    = s_valid && s_ready;
        mul_last  = (state_reg == ST_MUL) && (cnt_reg == MCW'(EW - 1));
        adj_we    = (state_reg == ST_WB) && !det_ph_reg && (op_reg == OP_S2);
        div_start = (state_reg == ST_DLD) && !sing_reg;
        out_load  = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
        op_neg    = !det_ph_reg && (op_reg == OP_T0_N || op_reg == OP_T1_N ||
                                    op_reg == OP_T2_N || op_reg == OP_S1);
        op_clr    = det_ph_reg ? (dk_reg == 2'd0)
                               : (op_reg == OP_T0_P || op_reg == OP_T1_P ||
                                  op_reg == OP_T2_P || op_reg == OP_S0);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && s_go) begin
                    state_next = ST_RDA;
                end
            end
            ST_RDA:  state_next = ST_RDB;
            ST_RDB:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_MUL;
            ST_MUL: begin
                if (mul_last) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                if (det_ph_reg && dk_reg == LAST_DET_TERM) begin
                    state_next = ST_ABS;
                end else begin
                    state_next = ST_RDA;
                end
            end
            ST_ABS:  state_next = ST_CMP;
            ST_CMP:  state_next = ST_DRD;
            ST_DRD:  state_next = ST_DLD;
            ST_DLD:  state_next = sing_reg ? ST_EMIT : ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    state_next = (ok_reg == LAST_ENTRY) ? ST_IDLE : ST_DRD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Parallel operand: an element for the 2x2 minors, a held 2x2 minor for
    // the top-row expansion, a stored cofactor for the determinant.
    always_comb begin
        if (det_ph_reg) begin
            b_sel = adj_rd_reg;
        end else begin
            case (op_reg)
                OP_S0:   b_sel = t0_reg;
                OP_S1:   b_sel = t1_reg;
                OP_S2:   b_sel = t2_reg;
                default: b_sel = {{(W - EW){mat_data[EW-1]}}, mat_data};
            endcase
        end
    end

    // The multiplier's top bit carries negative weight.
    always_comb begin
        if (!mplier_reg[0]) begin
            addend = '0;
        end else if (cnt_reg == MCW'(EW - 1)) begin
            addend = ~mcand_reg + ONE_W;
        end else begin
            addend = mcand_reg;
        end
        acc_sum = acc_reg + addend;
    end

    assign adj_wdata = (k_reg[2] ^ k_reg[0]) ? (~acc_reg + ONE_W) : acc_reg;

    // Singular when |D| * 2^32 < threshold * 2^(4*FRAC_BITS).
    assign thr_lhs = CW'(dabs_reg) << 32;
    assign thr_rhs = CW'(thr_reg) << (4 * FRAC_BITS);

    // Rounded quotient: (|C| * 2^(2F+1) + |D|) / (2 |D|).
    assign cabs    = adj_rd_reg[W-1] ? (~adj_rd_reg + ONE_W) : adj_rd_reg;
    assign div_num = (DW'(cabs) << (2 * FRAC_BITS + 1)) + DW'(dabs_reg);
    assign div_den = DW'(dabs_reg) << (EW + 2);

    mia_div #(
        .ELEM_WIDTH (EW),
        .DIV_WIDTH  (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    always_comb begin
        if (cneg_reg ^ det_neg_reg) begin
            q_sat = (div_q > LIM_NEG) ? LIM_NEG : div_q;
        end else begin
            q_sat = (div_q > LIM_POS) ? LIM_POS : div_q;
        end
        q_neg = ~q_sat + (EW + 2)'(1);
        if (sing_reg) begin
            out_val = '0;
        end else if (cneg_reg ^ det_neg_reg) begin
            out_val = q_neg[EW-1:0];
        end else begin
            out_val = q_sat[EW-1:0];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            vld_reg     <= '0;
            thr_reg     <= 32'd4295;
            op_reg      <= OP_T0_P;
            k_reg       <= '0;
            dk_reg      <= '0;
            det_ph_reg  <= 1'b0;
            ok_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                thr_reg <= cfg_data;
            end
            if (s_fire) begin
                vld_reg[{s_elem_row, s_elem_col}] <= 1'b1;
                op_reg     <= OP_T0_P;
                k_reg      <= '0;
                dk_reg     <= '0;
                det_ph_reg <= 1'b0;
            end
            if (state_reg == ST_WB) begin
                if (det_ph_reg) begin
                    dk_reg <= dk_reg + 2'd1;
                end else if (op_reg == OP_S2) begin
                    op_reg <= OP_T0_P;
                    if (k_reg == LAST_ENTRY) begin
                        det_ph_reg <= 1'b1;
                    end else begin
                        k_reg <= k_reg + 4'd1;
                    end
                end else begin
                    op_reg <= op_t'(op_reg + 4'd1);
                end
            end
            if (state_reg == ST_CMP) begin
                ok_reg <= '0;
            end
            if (out_load) begin
                ok_reg <= ok_reg + 4'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Memories.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mat_mem[{s_elem_row, s_elem_col}] <= s_elem_value;
        end
        mat_rd_reg  <= mat_mem[mat_addr];
        mat_rdv_reg <= vld_reg[mat_addr];
        if (adj_we) begin
            adj_mem[k_reg] <= adj_wdata;
        end
        adj_rd_reg <= adj_mem[adj_raddr];
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_RDB: mplier_reg <= mat_data;
            ST_LOAD: begin
                mcand_reg <= op_neg ? (~b_sel + ONE_W) : b_sel;
                cnt_reg   <= '0;
                if (op_clr) begin
                    acc_reg <= '0;
                end
            end
            ST_MUL: begin
                acc_reg    <= acc_sum;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= cnt_reg + MCW'(1);
            end
            ST_WB: begin
                if (!det_ph_reg) begin
                    case (op_reg)
                        OP_T0_N: t0_reg <= acc_reg;
                        OP_T1_N: t1_reg <= acc_reg;
                        OP_T2_N: t2_reg <= acc_reg;
                        default: ;
                    endcase
                end
            end
            ST_ABS: begin
                det_neg_reg <= acc_reg[W-1];
                dabs_reg    <= acc_reg[W-1] ? (~acc_reg + ONE_W) : acc_reg;
            end
            ST_CMP:  sing_reg <= (dabs_reg == '0) || (thr_lhs < thr_rhs);
            ST_DLD:  cneg_reg <= adj_rd_reg[W-1];
            default: ;
        endcase
        if (out_load) begin
            m_row_reg  <= ok_reg[3:2];
            m_col_reg  <= ok_reg[1:0];
            m_val_reg  <= out_val;
            m_sing_reg <= sing_reg;
            m_last_reg <= (ok_reg == LAST_ENTRY);
        end
    end

    // The threshold is only taken while no inversion is running.
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_out_value = m_val_reg;
    assign m_singular  = m_sing_reg;
    assign m_last      = m_last_reg;

endmodule

// File: rtl/mia_div.sv
`timescale 1ns / 1ps

module mia_div #(
    parameter int ELEM_WIDTH = 32,
    parameter int DIV_WIDTH  = 200
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [DIV_WIDTH-1:0]    num,
    input  logic [DIV_WIDTH-1:0]    den,
    output logic                    done,
    output logic [ELEM_WIDTH+1:0]   quot
);

    localparam int QW  = ELEM_WIDTH + 2;
    localparam int CNW = $clog2(QW);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNW-1:0]        cnt_reg;
    logic [DIV_WIDTH-1:0]  rem_reg;
    logic [DIV_WIDTH-1:0]  den_reg;
    logic [QW-1:0]         q_reg;
    logic [DIV_WIDTH:0]    diff;

    // Restoring division, one quotient bit per cycle from the top bit down.
    assign diff = {1'b0, rem_reg} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(QW - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            if (!diff[DIV_WIDTH]) begin
                rem_reg <= diff[DIV_WIDTH-1:0];
            end
            q_reg   <= {q_reg[QW-2:0], ~diff[DIV_WIDTH]};
            den_reg <= den_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: rtl/mia_chk.sv
`timescale 1ns / 1ps

module mia_chk #(
    parameter int ELEM_WIDTH = 32
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   s_go,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [1:0]             m_out_row,
    input logic [1:0]             m_out_col,
    input logic [ELEM_WIDTH-1:0]  m_out_value,
    input logic                   m_singular,
    input logic                   m_last
);

    // The last beat of a result set is always the bottom-right entry.
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_out_row == 2'd3 && m_out_col == 2'd3)
        else $error("last beat not at entry (3,3)");

    // A singular matrix yields only zeros.
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_out_value == '0)
        else $error("nonzero value on singular beat");

    // A go beat starts an inversion, so input is held off next cycle.
    a_go_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_go |=> !s_ready)
        else $error("input accepted right after go");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) && $stable(m_last))
        else $error("result beat changed while stalled");

endmodule

bind matrix_inverse_4x4 mia_chk #(.ELEM_WIDTH(ELEM_WIDTH)) u_mia_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_go        (s_go),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_row   (m_out_row),
    .m_out_col   (m_out_col),
    .m_out_value (m_out_value),
    .m_singular  (m_singular),
    .m_last      (m_last)
);
